// ===== hdl/pfi_pkg.sv =====
// ----------------------------------------------------------------------------
// pfi_pkg
// Shared types, widths and constants for the packet fault injector.
// ----------------------------------------------------------------------------
package pfi_pkg;

  localparam int HANDLE_BITS  = 16;
  localparam int COUNT_BITS   = 32;
  localparam int CNT_BITS     = $clog2(COUNT_BITS + 1);
  localparam int PERIOD_BITS  = 16;
  localparam int PROB_BITS    = 54;
  localparam int SEED_BITS    = 64;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 64;

  localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_A       = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_B       = 64'h94D049BB133111EB;
  localparam logic [63:0] SEED_OFFSET = 64'hD1B54A32D192ED03;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DROP_PERIOD    = 3'd0,
    CFG_REORDER_PERIOD = 3'd1,
    CFG_BURST_ENABLE   = 3'd2,
    CFG_BURST_SEED     = 3'd3,
    CFG_LOSS_GOOD      = 3'd4,
    CFG_LOSS_BAD       = 3'd5,
    CFG_GOOD_TO_BAD    = 3'd6,
    CFG_BAD_TO_GOOD    = 3'd7
  } pfi_cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED,
    S_ADV,
    S_MUL,
    S_TEST,
    S_DECIDE,
    S_DROP_WAIT,
    S_POST,
    S_HOLD_WAIT,
    S_SECOND
  } pfi_state_t;

  typedef struct packed {
    logic                   start;
    logic [COUNT_BITS-1:0]  dividend;
    logic [PERIOD_BITS-1:0] divisor;
  } pfi_rem_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } pfi_rem_stat_t;

endpackage

// ===== hdl/pfi_ifs.sv =====
// ----------------------------------------------------------------------------
// pfi_ifs
// Valid/ready channel interfaces for packet handles in and results out.
// ----------------------------------------------------------------------------
interface pfi_in_if;
  logic                            valid;
  logic                            ready;
  logic [pfi_pkg::HANDLE_BITS-1:0] packet_handle;
  logic                            is_control;

  modport source (output valid, output packet_handle, output is_control, input ready);
  modport sink   (input valid, input packet_handle, input is_control, output ready);
endinterface

interface pfi_out_if;
  logic                            valid;
  logic                            ready;
  logic [pfi_pkg::HANDLE_BITS-1:0] out_handle;
  logic                            was_held;
  logic                            out_last;

  modport source (output valid, output out_handle, output was_held, output out_last,
                  input ready);
  modport sink   (input valid, input out_handle, input was_held, input out_last,
                  output ready);
endinterface

// ===== hdl/pfi_remu.sv =====
// ----------------------------------------------------------------------------
// pfi_remu
// Iterative unsigned remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pfi_remu (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pfi_pkg::pfi_rem_req_t  req,
  output pfi_pkg::pfi_rem_stat_t stat
);
  import pfi_pkg::*;

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_BITS-1:0]    cnt_r;
  logic [COUNT_BITS-1:0]  dvd_r;
  logic [PERIOD_BITS-1:0] div_r;
  logic [PERIOD_BITS-1:0] rem_r;
  logic [PERIOD_BITS:0]   shifted;
  logic [PERIOD_BITS:0]   diff;

  // Restoring step: bring in the next dividend bit, subtract when it fits.
  assign shifted = {rem_r, dvd_r[COUNT_BITS-1]};
  assign diff    = shifted - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(COUNT_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      dvd_r <= req.dividend;
      div_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[COUNT_BITS-2:0], 1'b0};
      if (!diff[PERIOD_BITS]) begin
        rem_r <= diff[PERIOD_BITS-1:0];
      end else begin
        rem_r <= shifted[PERIOD_BITS-1:0];
      end
    end
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("remainder done while still iterating");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r))
    else $error("remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start)
    else $error("remainder unit started while busy");

endmodule

// ===== hdl/packet_fault_injector.sv =====
// A control packet, or any packet while all faults are off, is in the output register in the
// cycle after its transaction; one such packet is taken per cycle while the output is free.
// A counted packet goes through a burst step when enabled (two draws of one 64-bit mix with
// two 64x64 products on one 32x32 multiplier) and a period test on the shared remainder unit
// for each period in use (one dividend bit per cycle); the block takes one packet at a time.
// Reset (synchronous, active low) clears config registers, count, generator, chain state and the hold.
// ----------------------------------------------------------------------------
// packet_fault_injector
// Gilbert-Elliott burst loss with a splitmix64 source, periodic drop and
// periodic hold-and-swap reordering of packet handles.
// ----------------------------------------------------------------------------
module packet_fault_injector (
  input  logic                             clk,
  input  logic                             rst_n,
  pfi_in_if.sink                           in_ch,
  pfi_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [pfi_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [pfi_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import pfi_pkg::*;

  // Configuration registers.
  logic [PERIOD_BITS-1:0] drop_period_r;
  logic [PERIOD_BITS-1:0] reorder_period_r;
  logic                   burst_enable_r;
  logic [SEED_BITS-1:0]   burst_seed_r;
  logic [PROB_BITS-1:0]   loss_good_r;
  logic [PROB_BITS-1:0]   loss_bad_r;
  logic [PROB_BITS-1:0]   good_to_bad_r;
  logic [PROB_BITS-1:0]   bad_to_good_r;

  // Block state.
  pfi_state_t             state_r, state_nxt;
  logic [COUNT_BITS-1:0]  seen_count_r, seen_count_nxt;
  logic [63:0]            rng_state_r, rng_state_nxt;
  logic                   bad_state_r, bad_state_nxt;
  logic                   rng_seeded_r, rng_seeded_nxt;
  logic                   held_valid_r, held_valid_nxt;
  logic [HANDLE_BITS-1:0] held_handle_r, held_handle_nxt;
  logic [HANDLE_BITS-1:0] cur_handle_r, cur_handle_nxt;
  logic                   lost_r, lost_nxt;
  logic                   draw_r, draw_nxt;

  // Mixing datapath: one 32x32 multiplier walked through the partial products.
  logic [63:0]            z_r, z_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic [63:0]            prod_r;
  logic [1:0]             ph_r, ph_nxt;
  logic                   mul_sel_r, mul_sel_nxt;
  logic [63:0]            mix_const;
  logic [31:0]            mul_a;
  logic [31:0]            mul_b;
  logic [63:0]            mul_res;
  logic [63:0]            adv;
  logic [PROB_BITS-1:0]   draw_prob;
  logic                   draw_hit;

  // Output register.
  logic                   out_valid_r;
  logic [HANDLE_BITS-1:0] out_handle_r;
  logic                   was_held_r;
  logic                   out_last_r;
  logic                   out_load;
  logic [HANDLE_BITS-1:0] out_handle_ld;
  logic                   was_held_ld;
  logic                   out_last_ld;

  logic                   in_fire;
  logic                   out_free;
  logic                   faults_off;

  pfi_rem_req_t           rem_req;
  pfi_rem_stat_t          rem_stat;

  pfi_remu u_remu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .stat  (rem_stat)
  );

  // The output register is free when empty or when its transaction completes now.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign faults_off  = (drop_period_r == '0) && (reorder_period_r == '0) && !burst_enable_r;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_handle = out_handle_r;
  assign out_ch.was_held   = was_held_r;
  assign out_ch.out_last   = out_last_r;

  // Low 64 bits of z * C from three 32x32 products:
  // lo*lo, then lo*hi and hi*lo added into the upper word.
  assign mix_const = mul_sel_r ? MIX_B : MIX_A;
  assign mul_a     = (ph_r == 2'd2) ? z_r[63:32] : z_r[31:0];
  assign mul_b     = (ph_r == 2'd1) ? mix_const[63:32] : mix_const[31:0];
  assign mul_res   = {acc_r[63:32] + prod_r[31:0], acc_r[31:0]};
  assign adv       = rng_state_r + GOLDEN_STEP;

  // The first draw of a step tests loss, the second tests the state change.
  always_comb begin
    if (!draw_r) begin
      draw_prob = bad_state_r ? loss_bad_r : loss_good_r;
    end else begin
      draw_prob = bad_state_r ? bad_to_good_r : good_to_bad_r;
    end
  end
  assign draw_hit = {1'b0, z_r[63:11]} < draw_prob;

  always_comb begin
    state_nxt       = state_r;
    seen_count_nxt  = seen_count_r;
    rng_state_nxt   = rng_state_r;
    bad_state_nxt   = bad_state_r;
    rng_seeded_nxt  = rng_seeded_r;
    held_valid_nxt  = held_valid_r;
    held_handle_nxt = held_handle_r;
    cur_handle_nxt  = cur_handle_r;
    lost_nxt        = lost_r;
    draw_nxt        = draw_r;
    z_nxt           = z_r;
    acc_nxt         = acc_r;
    ph_nxt          = ph_r;
    mul_sel_nxt     = mul_sel_r;
    out_load        = 1'b0;
    out_handle_ld   = cur_handle_r;
    was_held_ld     = 1'b0;
    out_last_ld     = 1'b1;
    rem_req.start    = 1'b0;
    rem_req.dividend = seen_count_r;
    rem_req.divisor  = (state_r == S_DECIDE) ? drop_period_r : reorder_period_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cur_handle_nxt = in_ch.packet_handle;
          if (in_ch.is_control || faults_off) begin
            out_load      = 1'b1;
            out_handle_ld = in_ch.packet_handle;
          end else begin
            seen_count_nxt = seen_count_r + COUNT_BITS'(1);
            lost_nxt       = 1'b0;
            draw_nxt       = 1'b0;
            state_nxt      = burst_enable_r ? S_SEED : S_DECIDE;
          end
        end
      end
      S_SEED: begin
        // The generator is seeded once, at the first burst step after reset.
        if (!rng_seeded_r) begin
          rng_state_nxt  = burst_seed_r + SEED_OFFSET;
          bad_state_nxt  = 1'b0;
          rng_seeded_nxt = 1'b1;
        end
        state_nxt = S_ADV;
      end
      S_ADV: begin
        rng_state_nxt = adv;
        z_nxt         = adv ^ (adv >> 30);
        ph_nxt        = 2'd0;
        mul_sel_nxt   = 1'b0;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        ph_nxt = ph_r + 2'd1;
        unique case (ph_r)
          2'd0: begin
          end
          2'd1: begin
            acc_nxt = prod_r;
          end
          2'd2: begin
            acc_nxt = mul_res;
          end
          2'd3: begin
            if (!mul_sel_r) begin
              z_nxt       = mul_res ^ (mul_res >> 27);
              mul_sel_nxt = 1'b1;
            end else begin
              z_nxt     = mul_res ^ (mul_res >> 31);
              state_nxt = S_TEST;
            end
          end
        endcase
      end
      S_TEST: begin
        if (!draw_r) begin
          lost_nxt  = draw_hit;
          draw_nxt  = 1'b1;
          state_nxt = S_ADV;
        end else begin
          if (draw_hit) begin
            bad_state_nxt = !bad_state_r;
          end
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (lost_r) begin
          state_nxt = S_IDLE;
        end else if (drop_period_r != '0) begin
          rem_req.start = 1'b1;
          state_nxt     = S_DROP_WAIT;
        end else begin
          state_nxt = S_POST;
        end
      end
      S_DROP_WAIT: begin
        if (rem_stat.done) begin
          state_nxt = rem_stat.zero ? S_IDLE : S_POST;
        end
      end
      S_POST: begin
        // The output register is empty here: it was free when the packet came in.
        if (held_valid_r) begin
          out_load    = 1'b1;
          out_last_ld = 1'b0;
          state_nxt   = S_SECOND;
        end else if (reorder_period_r != '0) begin
          rem_req.start = 1'b1;
          state_nxt     = S_HOLD_WAIT;
        end else begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_HOLD_WAIT: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) begin
            held_handle_nxt = cur_handle_r;
            held_valid_nxt  = 1'b1;
          end else begin
            out_load = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_SECOND: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_handle_ld  = held_handle_r;
          was_held_ld    = 1'b1;
          held_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      seen_count_r <= '0;
      rng_state_r  <= '0;
      bad_state_r  <= 1'b0;
      rng_seeded_r <= 1'b0;
      held_valid_r <= 1'b0;
      lost_r       <= 1'b0;
      draw_r       <= 1'b0;
      ph_r         <= '0;
      mul_sel_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      seen_count_r <= seen_count_nxt;
      rng_state_r  <= rng_state_nxt;
      bad_state_r  <= bad_state_nxt;
      rng_seeded_r <= rng_seeded_nxt;
      held_valid_r <= held_valid_nxt;
      lost_r       <= lost_nxt;
      draw_r       <= draw_nxt;
      ph_r         <= ph_nxt;
      mul_sel_r    <= mul_sel_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    held_handle_r <= held_handle_nxt;
    cur_handle_r  <= cur_handle_nxt;
    z_r           <= z_nxt;
    acc_r         <= acc_nxt;
    prod_r        <= {32'b0, mul_a} * {32'b0, mul_b};
    if (out_load) begin
      out_handle_r <= out_handle_ld;
      was_held_r   <= was_held_ld;
      out_last_r   <= out_last_ld;
    end
  end

  // Configuration writes; bits above a register's width are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_period_r    <= '0;
      reorder_period_r <= '0;
      burst_enable_r   <= 1'b0;
      burst_seed_r     <= '0;
      loss_good_r      <= '0;
      loss_bad_r       <= '0;
      good_to_bad_r    <= '0;
      bad_to_good_r    <= '0;
    end else if (cfg_we) begin
      unique case (pfi_cfg_idx_t'(cfg_index))
        CFG_DROP_PERIOD:    drop_period_r    <= cfg_data[PERIOD_BITS-1:0];
        CFG_REORDER_PERIOD: reorder_period_r <= cfg_data[PERIOD_BITS-1:0];
        CFG_BURST_ENABLE:   burst_enable_r   <= cfg_data[0];
        CFG_BURST_SEED:     burst_seed_r     <= cfg_data[SEED_BITS-1:0];
        CFG_LOSS_GOOD:      loss_good_r      <= cfg_data[PROB_BITS-1:0];
        CFG_LOSS_BAD:       loss_bad_r       <= cfg_data[PROB_BITS-1:0];
        CFG_GOOD_TO_BAD:    good_to_bad_r    <= cfg_data[PROB_BITS-1:0];
        CFG_BAD_TO_GOOD:    bad_to_good_r    <= cfg_data[PROB_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // A released held packet always closes the results of its input.
  a_held_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && was_held_r) |-> out_last_r)
    else $error("held packet released without last flag");

  // The release of a held packet waits only behind the current packet's result.
  a_second_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SECOND) |-> (held_valid_r && out_valid_r))
    else $error("release state without a held packet or first result");

  // The packet count moves only right after an input transaction.
  a_count_on_input: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (seen_count_r != $past(seen_count_r))) |-> $past(in_fire))
    else $error("packet count changed without an input transaction");

endmodule

// ===== verif/tb_packet_fault_injector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_fault_injector
// Self-checking bench for the packet fault injector. A shadow model of the
// burst-loss chain, the periodic drop and the hold-and-swap logic predicts
// every forwarded handle. Directed cases come first, then randomized traffic
// over many register settings, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_packet_fault_injector;
  import pfi_pkg::*;

  // The watchdog limit is far above the slowest legal run. A counted packet
  // spends a burst step and period tests inside the block, and gaps and
  // stalls add to that.
  localparam int CYCLE_LIMIT     = 1_500_000;
  // The block may still be working on a packet that forwards nothing after
  // the last expected result has come out, so idle waits cover its latency.
  localparam int SETTLE_CYCLES   = 150;
  localparam int LONG_STALL      = 400;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 100;
  localparam logic [PROB_BITS-1:0] PROB_ONE = {1'b1, {(PROB_BITS-1){1'b0}}};

  typedef enum {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_MOSTLY} sink_mode_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic                   was_held;
    logic                   last;
  } fwd_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  pfi_in_if  in_ch ();
  pfi_out_if out_ch ();

  packet_fault_injector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the configuration registers, as the block sees them.
  logic [PERIOD_BITS-1:0] reg_drop        = '0;
  logic [PERIOD_BITS-1:0] reg_reorder     = '0;
  logic                   reg_burst       = 1'b0;
  logic [SEED_BITS-1:0]   reg_seed        = '0;
  logic [PROB_BITS-1:0]   reg_loss_good   = '0;
  logic [PROB_BITS-1:0]   reg_loss_bad    = '0;
  logic [PROB_BITS-1:0]   reg_good_to_bad = '0;
  logic [PROB_BITS-1:0]   reg_bad_to_good = '0;

  // Shadow copy of the injector state.
  logic [COUNT_BITS-1:0]  seen_cnt    = '0;
  logic [63:0]            gen_state   = '0;
  logic                   chain_bad   = 1'b0;
  logic                   gen_seeded  = 1'b0;
  logic                   hold_full   = 1'b0;
  logic [HANDLE_BITS-1:0] hold_handle = '0;

  // Handles the block should forward, oldest first.
  fwd_result_t forwarded_q[$];
  fwd_result_t head_r;

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  burst_left     = 0;
  bit  long_stall_req = 1'b0;

  // --------------------------------------------------------------------------
  // Clock and watchdog.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A hung handshake or a result that never arrives ends up here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shadow model.
  // --------------------------------------------------------------------------

  // The splitmix64 output function applied to one generator state.
  function automatic logic [63:0] splitmix_out(input logic [63:0] s);
    logic [63:0] z;
    z = s;
    z = (z ^ (z >> 30)) * MIX_A;
    z = (z ^ (z >> 27)) * MIX_B;
    z = z ^ (z >> 31);
    return z;
  endfunction

  // Advances the generator and returns the top 53 bits of the new output.
  function automatic logic [52:0] next_draw();
    gen_state = gen_state + GOLDEN_STEP;
    return splitmix_out(gen_state) >> 11;
  endfunction

  // One packet transaction: updates the shadow state and queues whatever the
  // block is expected to forward for it.
  function automatic void predict_packet(input logic [HANDLE_BITS-1:0] handle,
                                         input logic ctrl);
    logic                 lost;
    logic [52:0]          draw;
    logic [PROB_BITS-1:0] prob;
    lost = 1'b0;
    if (ctrl || (reg_drop == 0 && reg_reorder == 0 && !reg_burst)) begin
      forwarded_q.push_back('{handle, 1'b0, 1'b1});
      return;
    end
    seen_cnt = seen_cnt + 1'b1;
    if (reg_burst) begin
      // The generator is seeded once, at the first burst step after reset.
      if (!gen_seeded) begin
        gen_state  = reg_seed + SEED_OFFSET;
        chain_bad  = 1'b0;
        gen_seeded = 1'b1;
      end
      prob = chain_bad ? reg_loss_bad : reg_loss_good;
      draw = next_draw();
      lost = ({1'b0, draw} < prob);
      prob = chain_bad ? reg_bad_to_good : reg_good_to_bad;
      draw = next_draw();
      if ({1'b0, draw} < prob) chain_bad = ~chain_bad;
    end
    // A dropped packet leaves any held packet where it is.
    if (lost || (reg_drop != 0 && seen_cnt % reg_drop == 0)) return;
    if (hold_full) begin
      // The survivor goes first and the held packet follows; the survivor is
      // not itself a candidate for holding.
      forwarded_q.push_back('{handle, 1'b0, 1'b0});
      forwarded_q.push_back('{hold_handle, 1'b1, 1'b1});
      hold_full = 1'b0;
    end else if (reg_reorder != 0 && seen_cnt % reg_reorder == 0) begin
      hold_handle = handle;
      hold_full   = 1'b1;
    end else begin
      forwarded_q.push_back('{handle, 1'b0, 1'b1});
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: the receiver stalls on its own pattern, and the checker
  // compares every accepted transaction with the oldest expectation.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    sink_mode_t mode;
    int         mode_left;
    int         stall_left;
    mode       = SINK_OPEN;
    mode_left  = 0;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left     = LONG_STALL;
      end
      if (stall_left > 0) begin
        // Long hold-off: the block fills up and must stall its input.
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:   out_ch.ready <= 1'b1;
          SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          SINK_SLOW:   out_ch.ready <= ($urandom_range(0, 3) == 0);
          SINK_MOSTLY: out_ch.ready <= ($urandom_range(0, 7) != 0);
          default:     out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (forwarded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, handle %h held %b last %b",
                                  out_ch.out_handle, out_ch.was_held, out_ch.out_last));
      end else begin
        head_r = forwarded_q.pop_front();
        if (out_ch.out_handle !== head_r.handle)
          report_mismatch($sformatf("out_handle %h, expected %h",
                                    out_ch.out_handle, head_r.handle));
        if (out_ch.was_held !== head_r.was_held)
          report_mismatch($sformatf("was_held %b, expected %b for handle %h",
                                    out_ch.was_held, head_r.was_held, head_r.handle));
        if (out_ch.out_last !== head_r.last)
          report_mismatch($sformatf("out_last %b, expected %b for handle %h",
                                    out_ch.out_last, head_r.last, head_r.handle));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared driving tasks. All of them are entered right after a rising edge.
  // --------------------------------------------------------------------------

  // Offers one packet and returns at the edge where the transaction happens, or after a gap.
  // When paced, the sender works in bursts with random gaps in between;
  // otherwise valid simply stays high for the next packet.
  task automatic send_packet(input logic [HANDLE_BITS-1:0] handle, input logic ctrl,
                             input bit paced);
    int gap;
    in_ch.valid         <= 1'b1;
    in_ch.packet_handle <= handle;
    in_ch.is_control    <= ctrl;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predict_packet(handle, ctrl);
    if (paced) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 100) : $urandom_range(1, 15);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
        // Now and then a long burst with no idling at all.
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(0, 11);
      end
    end
  endtask

  // Writes one register and mirrors it, keeping only the register's width.
  task automatic write_register(input pfi_cfg_idx_t idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DROP_PERIOD:    reg_drop        = data[PERIOD_BITS-1:0];
      CFG_REORDER_PERIOD: reg_reorder     = data[PERIOD_BITS-1:0];
      CFG_BURST_ENABLE:   reg_burst       = data[0];
      CFG_BURST_SEED:     reg_seed        = data;
      CFG_LOSS_GOOD:      reg_loss_good   = data[PROB_BITS-1:0];
      CFG_LOSS_BAD:       reg_loss_bad    = data[PROB_BITS-1:0];
      CFG_GOOD_TO_BAD:    reg_good_to_bad = data[PROB_BITS-1:0];
      CFG_BAD_TO_GOOD:    reg_bad_to_good = data[PROB_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Brings the block to idle: input quiet, every expected result received,
  // and enough extra cycles for a packet that forwards nothing to finish.
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    while (forwarded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random period: mostly small so that the periods actually fire, with the
  // extremes and junk in the bits above the register width.
  function automatic logic [63:0] pick_period();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       v[PERIOD_BITS-1:0] = '0;
      1:       v[PERIOD_BITS-1:0] = 16'd1;
      2:       v[PERIOD_BITS-1:0] = '1;
      5:       ;
      default: v[PERIOD_BITS-1:0] = PERIOD_BITS'($urandom_range(2, 9));
    endcase
    return v;
  endfunction

  // Random probability: never, always, all ones, a fraction below one, or raw random bits.
  function automatic logic [63:0] pick_prob();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       v[PROB_BITS-1:0] = '0;
      1:       v[PROB_BITS-1:0] = PROB_ONE;
      2:       v[PROB_BITS-1:0] = '1;
      3:       v[PROB_BITS-1:0] = {1'b0, v[PROB_BITS-2:0]} >> $urandom_range(1, 6);
      4:       v[PROB_BITS-1:0] = {1'b0, v[PROB_BITS-2:0]};
      default: ;
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // With every fault off after reset, each packet passes straight through.
  task automatic test_passthrough();
    send_packet(16'h0000, 1'b0, 1'b1);
    send_packet(16'hFFFF, 1'b0, 1'b1);
    send_packet(16'hFFFF, 1'b1, 1'b1);
    send_packet(16'h0000, 1'b1, 1'b1);
    send_packet(HANDLE_BITS'($urandom), 1'b0, 1'b1);
    settle_idle();
  endtask

  // A drop period of one kills every counted packet; control packets still pass.
  task automatic test_control_bypass();
    write_register(CFG_DROP_PERIOD, 64'd1);
    send_packet(16'h1234, 1'b0, 1'b1);
    send_packet(16'hFFFF, 1'b1, 1'b1);
    send_packet(16'h0000, 1'b1, 1'b1);
    send_packet(HANDLE_BITS'($urandom), 1'b0, 1'b1);
    settle_idle();
  endtask

  task automatic test_periodic_drop();
    write_register(CFG_DROP_PERIOD, 64'd3);
    repeat (4) send_packet(HANDLE_BITS'($urandom), 1'b0, 1'b1);
    settle_idle();
  endtask

  // A reorder period of one meets the case of an occupied hold: the next
  // survivor releases the held packet and is not held itself. Then the last
  // packet stays held under new periods until the next survivor releases it.
  task automatic test_reorder();
    write_register(CFG_DROP_PERIOD, 64'd0);
    write_register(CFG_REORDER_PERIOD, 64'd1);
    repeat (3) send_packet(HANDLE_BITS'($urandom), 1'b0, 1'b1);
    settle_idle();
    write_register(CFG_DROP_PERIOD, 64'd3);
    write_register(CFG_REORDER_PERIOD, 64'd2);
    send_packet(16'hFFFF, 1'b0, 1'b1);
    repeat (3) send_packet(HANDLE_BITS'($urandom), 1'b0, 1'b1);
    settle_idle();
  endtask

  // The seed is written before the first burst step, so it is the one used.
  // Certain loss in the good state with a certain move to bad, then a bad
  // state that never loses; later a forced return to good.
  task automatic test_burst_loss();
    write_register(CFG_DROP_PERIOD, 64'd0);
    write_register(CFG_REORDER_PERIOD, 64'd0);
    write_register(CFG_BURST_SEED, {$urandom, $urandom});
    write_register(CFG_LOSS_GOOD, 64'(PROB_ONE));
    write_register(CFG_LOSS_BAD, 64'd0);
    write_register(CFG_GOOD_TO_BAD, 64'(PROB_ONE) | (64'(PROB_ONE) - 1));
    write_register(CFG_BAD_TO_GOOD, 64'd0);
    write_register(CFG_BURST_ENABLE, 64'd1);
    repeat (3) send_packet(HANDLE_BITS'($urandom), 1'b0, 1'b1);
    settle_idle();
    write_register(CFG_BAD_TO_GOOD, 64'(PROB_ONE));
    write_register(CFG_LOSS_BAD, 64'(PROB_ONE) >> 1);
    repeat (3) send_packet(HANDLE_BITS'($urandom), 1'b0, 1'b1);
    settle_idle();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering back to back, so the block fills and stalls its input.
  task automatic test_backpressure();
    write_register(CFG_BURST_ENABLE, 64'd0);
    write_register(CFG_DROP_PERIOD, 64'd0);
    write_register(CFG_REORDER_PERIOD, 64'd2);
    long_stall_req = 1'b1;
    repeat (24) send_packet(HANDLE_BITS'($urandom), 1'($urandom_range(0, 1)), 1'b0);
    settle_idle();
  endtask

  // Random traffic over a series of random register settings.
  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_register(CFG_DROP_PERIOD, pick_period());
      write_register(CFG_REORDER_PERIOD, pick_period());
      write_register(CFG_BURST_SEED, {$urandom, $urandom});
      write_register(CFG_LOSS_GOOD, pick_prob());
      write_register(CFG_LOSS_BAD, pick_prob());
      write_register(CFG_GOOD_TO_BAD, pick_prob());
      write_register(CFG_BAD_TO_GOOD, pick_prob());
      write_register(CFG_BURST_ENABLE, {$urandom, $urandom});
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_packet(HANDLE_BITS'($urandom), ($urandom_range(0, 7) == 0), 1'b1);
      settle_idle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_DROP_PERIOD;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.packet_handle = '0;
    in_ch.is_control    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_passthrough();
    test_control_bypass();
    test_periodic_drop();
    test_reorder();
    test_burst_loss();
    test_backpressure();
    test_random_traffic();

    settle_idle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
